@@ design/sivr_pkg.sv @@
// sivr_pkg: shared types and constants of the solar input voltage regulator
// holds run state codes, register indexes, deadband and status thresholds
// no dependencies
`default_nettype none

package sivr_pkg;

  // run state codes
  localparam logic [2:0] ST_OFF     = 3'd0;
  localparam logic [2:0] ST_MPPT    = 3'd1;
  localparam logic [2:0] ST_CAPPED  = 3'd2;
  localparam logic [2:0] ST_FULL_CV = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_SETPOINT = 2'd0;
  localparam logic [1:0] REG_GAIN     = 2'd1;
  localparam logic [1:0] REG_RAMP     = 2'd2;
  localparam logic [1:0] REG_CAP      = 2'd3;

  // configuration reset values
  localparam logic [15:0] SETPOINT_RST = 16'd0;
  localparam logic [15:0] GAIN_RST     = 16'd256;
  localparam logic [15:0] RAMP_RST     = 16'd100;
  localparam logic [15:0] CAP_RST      = 16'd10000;

  // deadband and quick-adjust thresholds in mV
  localparam logic signed [16:0] DEADBAND_HI = 17'sd300;
  localparam logic signed [16:0] DEADBAND_LO = -17'sd200;
  localparam logic signed [16:0] QUICK_LIM   = 17'sd600;

  // status thresholds
  localparam logic [15:0] AGE_ON_LIM   = 16'd11;
  localparam logic [15:0] AGE_OFF_LIM  = 16'd120;
  localparam logic [15:0] VIN_LIVE_MV  = 16'd1000;
  localparam logic [22:0] CAP_PCT_NUM  = 23'd95;
  localparam logic [22:0] CAP_PCT_DEN  = 23'd100;

  typedef struct packed {
    logic [15:0] setpoint_mv;
    logic [15:0] gain_q8;
    logic [15:0] ramp_ma;
    logic [15:0] cap_ma;
  } cfg_t;

  typedef struct packed {
    logic [15:0] vin_mv;
    logic [15:0] limit_ma;
    logic [15:0] iout_ma;
    logic        out_en;
    logic        cv;
    logic        present;
    logic [15:0] age_s;
  } meas_t;

  typedef struct packed {
    logic [15:0] desired_ma;
    logic        adjust;
    logic        quick;
    logic [2:0]  run_state;
  } res_t;

endpackage

`default_nettype wire

@@ design/sivr_cfg.sv @@
// sivr_cfg: configuration register file of the regulator
// depends on sivr_pkg for register indexes and reset values
`default_nettype none

module sivr_cfg
  import sivr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  // register writes, one index per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint_mv <= SETPOINT_RST;
      cfg_q.gain_q8     <= GAIN_RST;
      cfg_q.ramp_ma     <= RAMP_RST;
      cfg_q.cap_ma      <= CAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SETPOINT: cfg_q.setpoint_mv <= cfg_wdata_i;
        REG_GAIN:     cfg_q.gain_q8     <= cfg_wdata_i;
        REG_RAMP:     cfg_q.ramp_ma     <= cfg_wdata_i;
        REG_CAP:      cfg_q.cap_ma      <= cfg_wdata_i;
        default:      cfg_q.cap_ma      <= cfg_q.cap_ma;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/sivr_calc.sv @@
// sivr_calc: combinational datapath for one measurement word
// proportional step, clamp, deadband, cap and run state classification
// depends on sivr_pkg
`default_nettype none

module sivr_calc
  import sivr_pkg::*;
(
  input  wire cfg_t        cfg_i,
  input  wire meas_t       meas_i,
  input  wire logic [2:0]  state_i,
  output res_t             res_o
);

  logic               corr_en;
  logic signed [16:0] err;
  logic signed [33:0] prod;
  logic signed [33:0] hi_lim;
  logic signed [33:0] lo_lim;
  logic signed [33:0] prod_clamp;
  logic signed [17:0] step;
  logic signed [18:0] sum;
  logic signed [18:0] cap_s;
  logic [15:0]        prop;
  logic               outside;
  logic [22:0]        iout_scaled;
  logic [22:0]        cap_scaled;
  logic [2:0]         next_state;

  assign corr_en = (cfg_i.setpoint_mv != 16'd0) && meas_i.present && meas_i.out_en;

  // error and gain product, exact
  assign err  = $signed({1'b0, meas_i.vin_mv}) - $signed({1'b0, cfg_i.setpoint_mv});
  assign prod = err * $signed({1'b0, cfg_i.gain_q8});

  // clamp to minus twice the ramp up to the ramp, in Q8.8
  assign hi_lim = $signed({10'b0, cfg_i.ramp_ma, 8'b0});
  assign lo_lim = -$signed({9'b0, cfg_i.ramp_ma, 9'b0});

  always_comb begin
    if (prod > hi_lim) begin
      prod_clamp = hi_lim;
    end else if (prod < lo_lim) begin
      prod_clamp = lo_lim;
    end else begin
      prod_clamp = prod;
    end
  end

  // floor divide by 256 is the arithmetic shift
  assign step = prod_clamp[25:8];

  // proposal, capped and floored at zero
  assign sum   = $signed({3'b0, meas_i.limit_ma}) + step;
  assign cap_s = $signed({3'b0, cfg_i.cap_ma});

  always_comb begin
    if (sum > cap_s) begin
      prop = cfg_i.cap_ma;
    end else if (sum < 19'sd0) begin
      prop = 16'd0;
    end else begin
      prop = sum[15:0];
    end
  end

  assign outside = (err > DEADBAND_HI) || (err < DEADBAND_LO);

  // run state classification
  assign iout_scaled = {7'b0, meas_i.iout_ma} * CAP_PCT_DEN;
  assign cap_scaled  = {7'b0, cfg_i.cap_ma} * CAP_PCT_NUM;

  always_comb begin
    if (!meas_i.present) begin
      next_state = ST_ERROR;
    end else if (meas_i.out_en) begin
      if (meas_i.age_s > AGE_ON_LIM) begin
        next_state = ST_ERROR;
      end else if (iout_scaled > cap_scaled) begin
        next_state = ST_CAPPED;
      end else if (meas_i.cv) begin
        next_state = ST_FULL_CV;
      end else begin
        next_state = ST_MPPT;
      end
    end else if ((meas_i.vin_mv > VIN_LIVE_MV) && (meas_i.age_s > AGE_OFF_LIM)) begin
      next_state = ST_ERROR;
    end else begin
      next_state = ST_OFF;
    end
  end

  // result word
  always_comb begin
    res_o.run_state = next_state;
    if (corr_en && outside) begin
      res_o.desired_ma = prop;
      res_o.adjust     = 1'b1;
      res_o.quick      = (err < QUICK_LIM) && (state_i == ST_MPPT);
    end else begin
      res_o.desired_ma = meas_i.present ? meas_i.limit_ma : 16'd0;
      res_o.adjust     = 1'b0;
      res_o.quick      = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/solar_input_voltage_regulator_unit.sv @@
// solar_input_voltage_regulator_unit: top level of the input voltage regulator
// an accepted input word passes through the input register and then the result register to the output
// throughput: one word per cycle while the output is not stalled, set by the input register and result register
// the run state is updated as each word moves into the result register
// reset: run state off, registers at their defaults, both stages empty
// depends on sivr_pkg, sivr_cfg, sivr_calc
`default_nettype none

module solar_input_voltage_regulator_unit
  import sivr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] input_voltage_mv_i,
  input  wire logic [15:0] limit_current_ma_i,
  input  wire logic [15:0] output_current_ma_i,
  input  wire logic        output_enabled_i,
  input  wire logic        constant_voltage_i,
  input  wire logic        supply_present_i,
  input  wire logic [15:0] comms_age_s_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      desired_current_ma_o,
  output logic             adjust_needed_o,
  output logic             quick_adjust_o,
  output logic [2:0]       run_state_o
);

  cfg_t        cfg;
  meas_t       meas_q;
  logic        meas_vld_q;
  res_t        res;
  res_t        res_q;
  logic        res_vld_q;
  logic [2:0]  state_q;
  logic        res_ready;
  logic        meas_ready;
  logic        in_acc;
  logic        move;

  sivr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // pipeline handshake
  assign res_ready  = !res_vld_q || !out_stall_i;
  assign meas_ready = !meas_vld_q || res_ready;
  assign in_stall_o = !meas_ready;
  assign in_acc     = in_valid_i && meas_ready;
  assign move       = meas_vld_q && res_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_vld_q <= 1'b0;
    end else if (meas_ready) begin
      meas_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q.vin_mv   <= input_voltage_mv_i;
      meas_q.limit_ma <= limit_current_ma_i;
      meas_q.iout_ma  <= output_current_ma_i;
      meas_q.out_en   <= output_enabled_i;
      meas_q.cv       <= constant_voltage_i;
      meas_q.present  <= supply_present_i;
      meas_q.age_s    <= comms_age_s_i;
    end
  end

  sivr_calc u_calc (
    .cfg_i   (cfg),
    .meas_i  (meas_q),
    .state_i (state_q),
    .res_o   (res)
  );

  // result register and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      state_q   <= ST_OFF;
    end else begin
      if (res_ready) begin
        res_vld_q <= meas_vld_q;
      end
      if (move) begin
        state_q <= res.run_state;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res;
    end
  end

  assign out_valid_o          = res_vld_q;
  assign desired_current_ma_o = res_q.desired_ma;
  assign adjust_needed_o      = res_q.adjust;
  assign quick_adjust_o       = res_q.quick;
  assign run_state_o          = res_q.run_state;

endmodule

`default_nettype wire

@@ sim/solar_input_voltage_regulator_unit_tb.sv @@
// solar_input_voltage_regulator_unit_tb: self-checking bench for the input voltage regulator
// drives measurement words with random gaps and result stalls, predicts each result
// depends on sivr_pkg and solar_input_voltage_regulator_unit

module solar_input_voltage_regulator_unit_tb;
  import sivr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TICKS_PER_PHASE = 180;
  localparam int unsigned SETTLE_CYCLES = 4;

  // dut ports, all inputs known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_SETPOINT;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] input_voltage_mv_i = '0;
  logic [15:0] limit_current_ma_i = '0;
  logic [15:0] output_current_ma_i = '0;
  logic        output_enabled_i = 1'b0;
  logic        constant_voltage_i = 1'b0;
  logic        supply_present_i = 1'b0;
  logic [15:0] comms_age_s_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] desired_current_ma_o;
  logic        adjust_needed_o;
  logic        quick_adjust_o;
  logic [2:0]  run_state_o;

  // regulator settings and run state as the bench sees them
  logic [15:0] m_setpoint = SETPOINT_RST;
  logic [15:0] m_gain     = GAIN_RST;
  logic [15:0] m_ramp     = RAMP_RST;
  logic [15:0] m_cap      = CAP_RST;
  logic [2:0]  m_state    = ST_OFF;

  // pending input words and expected results, ring buffers
  meas_t       tick_buf [2048];
  logic [10:0] tick_wr = '0;
  logic [10:0] tick_rd = '0;
  res_t        due_buf [16];
  logic [3:0]  due_wr = '0;
  logic [3:0]  due_rd = '0;
  meas_t       cur_tick = '0;
  bit          feeding = 1'b0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;

  solar_input_voltage_regulator_unit i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .input_voltage_mv_i  (input_voltage_mv_i),
    .limit_current_ma_i  (limit_current_ma_i),
    .output_current_ma_i (output_current_ma_i),
    .output_enabled_i    (output_enabled_i),
    .constant_voltage_i  (constant_voltage_i),
    .supply_present_i    (supply_present_i),
    .comms_age_s_i       (comms_age_s_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .desired_current_ma_o(desired_current_ma_o),
    .adjust_needed_o     (adjust_needed_o),
    .quick_adjust_o      (quick_adjust_o),
    .run_state_o         (run_state_o)
  );

  // one regulation tick: proposed limit, flags and next run state
  function automatic res_t regulate_tick(meas_t m);
    res_t       r;
    longint     err;
    longint     prod;
    longint     hi;
    longint     lo;
    longint     want;
    logic [2:0] nxt;
    r = '0;
    want = m.present ? longint'(m.limit_ma) : 0;
    if (m_setpoint != 0 && m.present && m.out_en) begin
      err  = longint'(m.vin_mv) - longint'(m_setpoint);
      prod = err * longint'(m_gain);
      hi   = longint'(m_ramp) * 256;
      lo   = -2 * hi;
      if (prod > hi) prod = hi;
      if (prod < lo) prod = lo;
      if (err > DEADBAND_HI || err < DEADBAND_LO) begin
        r.adjust = 1'b1;
        r.quick  = (err < QUICK_LIM) && (m_state == ST_MPPT);
        // arithmetic shift floors the Q8.8 step toward minus infinity
        want = longint'(m.limit_ma) + (prod >>> 8);
        if (want > longint'(m_cap)) want = longint'(m_cap);
        if (want < 0) want = 0;
      end
    end
    // run state classification
    if (!m.present) begin
      nxt = ST_ERROR;
    end else if (m.out_en) begin
      if (m.age_s > AGE_ON_LIM) nxt = ST_ERROR;
      else if (longint'(m.iout_ma) * CAP_PCT_DEN > longint'(m_cap) * CAP_PCT_NUM)
        nxt = ST_CAPPED;
      else if (m.cv) nxt = ST_FULL_CV;
      else nxt = ST_MPPT;
    end else begin
      if (m.vin_mv > VIN_LIVE_MV && m.age_s > AGE_OFF_LIM) nxt = ST_ERROR;
      else nxt = ST_OFF;
    end
    m_state = nxt;
    r.desired_ma = want[15:0];
    r.run_state  = nxt;
    return r;
  endfunction

  function automatic meas_t mk_tick(int unsigned vin, int unsigned limit, int unsigned iout,
                                    bit en, bit cv, bit present, int unsigned age);
    meas_t m;
    m.vin_mv   = vin[15:0];
    m.limit_ma = limit[15:0];
    m.iout_ma  = iout[15:0];
    m.out_en   = en;
    m.cv       = cv;
    m.present  = present;
    m.age_s    = age[15:0];
    return m;
  endfunction

  function automatic int clip16(int v);
    return (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
  endfunction

  // mostly words near the setpoint and the capped threshold, the rest noise
  function automatic meas_t random_tick();
    meas_t m;
    int    thr;
    if ($urandom_range(0, 9) < 8) begin
      thr = (int'(m_cap) * 95) / 100;
      m.vin_mv   = 16'(clip16(int'(m_setpoint) + int'($urandom_range(0, 3000)) - 1500));
      m.limit_ma = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)
                                               : 16'($urandom_range(0, 12000));
      m.iout_ma  = ($urandom_range(0, 2) == 0)
                   ? 16'(clip16(thr + int'($urandom_range(0, 40)) - 20))
                   : 16'($urandom_range(0, 65535));
      m.out_en   = ($urandom_range(0, 7) != 0);
      m.cv       = ($urandom_range(0, 3) == 0);
      m.present  = ($urandom_range(0, 15) != 0);
      m.age_s    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 140))
                                               : 16'($urandom_range(0, 14));
    end else begin
      m = meas_t'({$urandom, $urandom, $urandom});
    end
    return m;
  endfunction

  function automatic logic [15:0] pick_reg(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  // append one input word to the pending ring
  task automatic queue_tick(meas_t m);
    tick_buf[tick_wr] = m;
    tick_wr = tick_wr + 11'd1;
  endtask

  // register write, only issued while the regulator is idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_SETPOINT: m_setpoint = val;
      REG_GAIN:     m_gain     = val;
      REG_RAMP:     m_ramp     = val;
      REG_CAP:      m_cap      = val;
      default:      ;
    endcase
  endtask

  task automatic write_all(logic [15:0] sp, logic [15:0] gn, logic [15:0] rp, logic [15:0] cp);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_GAIN, gn);
    write_reg(REG_RAMP, rp);
    write_reg(REG_CAP, cp);
  endtask

  task automatic wait_idle();
    while (tick_wr != tick_rd || feeding || due_wr != due_rd) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic report(string field, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      fails++;
    end
  endtask

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // input word driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (feeding && in_valid_i && !in_stall_o) begin
        due_buf[due_wr] = regulate_tick(cur_tick);
        due_wr = due_wr + 4'd1;
        feeding = 1'b0;
        in_gap  = in_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      end
      if (!feeding && tick_wr != tick_rd) begin
        if (in_gap == 0) begin
          cur_tick = tick_buf[tick_rd];
          tick_rd  = tick_rd + 11'd1;
          feeding  = 1'b1;
        end else begin
          in_gap--;
        end
      end
      in_valid_i          <= feeding;
      input_voltage_mv_i  <= cur_tick.vin_mv;
      limit_current_ma_i  <= cur_tick.limit_ma;
      output_current_ma_i <= cur_tick.iout_ma;
      output_enabled_i    <= cur_tick.out_en;
      constant_voltage_i  <= cur_tick.cv;
      supply_present_i    <= cur_tick.present;
      comms_age_s_i       <= cur_tick.age_s;
    end
  end

  // result word monitor and stall generator
  always @(posedge clk_i) begin : result_mon
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_wr == due_rd) begin
          $display("%0t: unexpected result, expected none, actual desired %0d state %0d",
                   $time, desired_current_ma_o, run_state_o);
          fails++;
        end else begin
          want   = due_buf[due_rd];
          due_rd = due_rd + 4'd1;
          report("desired_current_ma", 32'(want.desired_ma), 32'(desired_current_ma_o));
          report("adjust_needed", 32'(want.adjust), 32'(adjust_needed_o));
          report("quick_adjust", 32'(want.quick), 32'(quick_adjust_o));
          report("run_state", 32'(want.run_state), 32'(run_state_o));
        end
        out_hold = out_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      end else if (out_hold != 0) begin
        out_hold--;
      end
      out_stall_i <= (out_hold != 0);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero setpoint leaves the limit alone
    queue_tick(mk_tick(18000, 3000, 100, 1, 0, 1, 0));
    queue_tick(mk_tick(0, 65535, 0, 1, 0, 0, 0));
    queue_tick(mk_tick(1001, 500, 0, 0, 0, 1, 121));
    wait_idle();

    // directed corner words around setpoint 18000, cap 5000
    write_all(16'd18000, 16'd512, 16'd200, 16'd5000);
    queue_tick(mk_tick(20000, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(18300, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(17800, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(18301, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(18599, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(18600, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(17799, 1000, 1000, 1, 0, 1, 0));
    queue_tick(mk_tick(0, 100, 0, 1, 0, 1, 0));
    queue_tick(mk_tick(65535, 65535, 0, 1, 0, 1, 0));
    queue_tick(mk_tick(18000, 4000, 4750, 1, 0, 1, 0));
    queue_tick(mk_tick(18000, 4000, 4751, 1, 0, 1, 0));
    queue_tick(mk_tick(18000, 4000, 100, 1, 1, 1, 0));
    queue_tick(mk_tick(18000, 4000, 100, 1, 0, 1, 11));
    queue_tick(mk_tick(18000, 4000, 100, 1, 0, 1, 12));
    queue_tick(mk_tick(1000, 4000, 100, 0, 0, 1, 121));
    queue_tick(mk_tick(1001, 4000, 100, 0, 0, 1, 120));
    queue_tick(mk_tick(65535, 65535, 65535, 0, 1, 1, 65535));
    queue_tick(mk_tick(18000, 4000, 65535, 1, 0, 1, 65535));
    queue_tick(mk_tick(65535, 65535, 65535, 1, 1, 0, 65535));
    queue_tick(mk_tick(18301, 0, 0, 1, 1, 1, 0));
    wait_idle();

    // random phases, the first two at the register extremes
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      else if (ph == 1) write_all(16'd1, 16'd0, 16'd0, 16'd0);
      else write_all(($urandom_range(0, 7) == 0) ? 16'd0 : pick_reg(1000, 40000),
                     pick_reg(1, 2048), pick_reg(0, 3000), pick_reg(0, 20000));
      for (int n = 0; n < TICKS_PER_PHASE; n++) queue_tick(random_tick());
      wait_idle();
    end

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
